// ===== design/cbm_pkg.sv =====
`default_nettype none
package cbm_pkg;

  localparam int RAM_DEPTH     = 131072;
  localparam int RAM_AW        = $clog2(RAM_DEPTH);
  localparam int RAM_OFF_W     = 18;
  localparam int ROM_ADDR_BITS = 23;
  localparam int ROM_OFF_W     = 24;

  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_BITS    = 8 + ROM_ADDR_BITS + 1 + 32;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;

  localparam logic [2:0] KIND_ROM   = 3'd0;
  localparam logic [2:0] KIND_MBC1  = 3'd1;
  localparam logic [2:0] KIND_MBC2  = 3'd2;
  localparam logic [2:0] KIND_MBC3  = 3'd3;
  localparam logic [2:0] KIND_MBC5  = 3'd4;
  localparam logic [2:0] KIND_OTHER = 3'd5;

  localparam logic [1:0] REQ_ROM_RD = 2'd0;
  localparam logic [1:0] REQ_ROM_WR = 2'd1;
  localparam logic [1:0] REQ_RAM_RD = 2'd2;
  localparam logic [1:0] REQ_RAM_WR = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_MAPPER_KIND = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HAS_RAM     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HAS_BATTERY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROM_BYTES   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RAM_BYTES   = 3'd4;

  localparam logic [7:0] BYTE_ERASED = 8'hFF;

  typedef struct packed {
    logic              en;
    logic [RAM_AW-1:0] addr;
    logic [7:0]        data;
  } ram_wr_t;

endpackage
`default_nettype wire

// ===== design/cartridge_bank_mapper.sv =====
// Cartridge bank mapper: one CPU bus access per input word, one result word per access, in
// order. A new word can be accepted every cycle once the reset sweep is done and while the
// output is not stalled; a result passes from the cartridge RAM read register and stage one
// through the compare and write-back stage into the output register. Writes to the mapper
// registers take effect for the very next word, and back-to-back accesses to the same RAM
// byte see each other through a forwarding path. After reset all 131072 RAM bytes are set to
// 0xFF by a sweep, one byte per cycle, during which in_tready stays low; configuration writes are taken at any time.
`default_nettype none
module cartridge_bank_mapper (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // address[15:0], write_value[23:16]
  input  wire logic [cbm_pkg::IN_TDATA_W-1:0]     in_tdata,
  // req_type[1:0]
  input  wire logic [cbm_pkg::IN_TUSER_W-1:0]     in_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // read_data[7:0], rom_address[30:8], save_dirty[31], change_count[63:32]
  output logic      [cbm_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // rom_valid[0]
  output logic                                    out_tuser,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [cbm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [cbm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int RAW  = cbm_pkg::RAM_AW;
  localparam int ROW  = cbm_pkg::RAM_OFF_W;
  localparam int POW  = cbm_pkg::ROM_OFF_W;
  localparam int RABW = cbm_pkg::ROM_ADDR_BITS;

  // configuration
  logic [2:0]  kind_r;
  logic        has_ram_r;
  logic        has_bat_r;
  logic [23:0] rom_bytes_r;
  logic [17:0] ram_bytes_r;

  // mapper registers
  logic [8:0]  rom_bank_r, rom_bank_nxt;
  logic [3:0]  ram_bank_r, ram_bank_nxt;
  logic        ram_en_r, ram_en_nxt;
  logic        bank_mode_r, bank_mode_nxt;

  logic        dirty_r, dirty_nxt;
  logic [31:0] count_r, count_nxt;

  // stage one
  logic            s1_valid_r;
  logic [1:0]      s1_req_r;
  logic            s1_ram_ok_r;
  logic [RAW-1:0]  s1_addr_r;
  logic [7:0]      s1_wval_r;
  logic [RABW-1:0] s1_raddr_r;
  logic            s1_rvalid_r;

  logic                             out_valid_r;
  logic [cbm_pkg::OUT_TDATA_W-1:0]  out_data_r;
  logic                             out_user_r;

  logic [15:0]     addr;
  logic [7:0]      val;
  logic [1:0]      req;
  logic            accept, s1_adv, clr_busy;
  logic            banked, rom_mapped, rom_ok;
  logic [POW-1:0]  rom_off;
  logic            ram_access, ram_ok;
  logic [ROW-1:0]  ram_off, ram_lim;
  logic [7:0]      wval;
  logic [7:0]      old_byte, rd_byte;
  logic            s1_we;
  cbm_pkg::ram_wr_t wr;

  assign addr = in_tdata[15:0];
  assign val  = in_tdata[23:16];
  assign req  = in_tuser;

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !clr_busy && (!s1_valid_r || s1_adv);
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r      <= cbm_pkg::KIND_ROM;
      has_ram_r   <= 1'b0;
      has_bat_r   <= 1'b0;
      rom_bytes_r <= '0;
      ram_bytes_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        cbm_pkg::CFG_MAPPER_KIND: kind_r      <= cfg_data[2:0];
        cbm_pkg::CFG_HAS_RAM:     has_ram_r   <= cfg_data[0];
        cbm_pkg::CFG_HAS_BATTERY: has_bat_r   <= cfg_data[0];
        cbm_pkg::CFG_ROM_BYTES:   rom_bytes_r <= cfg_data[23:0];
        cbm_pkg::CFG_RAM_BYTES:   ram_bytes_r <= cfg_data[17:0];
        default: ;
      endcase
    end
  end

  // rom mapping
  always_comb begin
    banked     = (kind_r >= cbm_pkg::KIND_MBC1) && (kind_r <= cbm_pkg::KIND_MBC5);
    rom_mapped = !addr[15] && (!addr[14] || banked || kind_r == cbm_pkg::KIND_ROM);
    if (addr[14] && banked) begin
      rom_off = POW'({rom_bank_r, addr[13:0]});
    end else begin
      rom_off = POW'(addr);
    end
    rom_ok = rom_mapped && (rom_off < rom_bytes_r) && ((rom_off >> RABW) == '0);
  end

  // ram addressing
  always_comb begin
    ram_access = (has_ram_r || kind_r == cbm_pkg::KIND_MBC2)
              && (kind_r == cbm_pkg::KIND_ROM || ram_en_r);
    if (kind_r == cbm_pkg::KIND_MBC2) begin
      ram_off = ROW'(addr[8:0]);
      ram_lim = ROW'(512);
      wval    = {4'h0, val[3:0]};
    end else begin
      ram_off = ROW'({ram_bank_r, 13'h0000}) + ROW'(addr);
      ram_lim = (ram_bytes_r < ROW'(cbm_pkg::RAM_DEPTH)) ? ram_bytes_r
                                                          : ROW'(cbm_pkg::RAM_DEPTH);
      wval    = val;
    end
    ram_ok = ram_access && (ram_off < ram_lim);
  end

  // mapper register writes
  always_comb begin
    rom_bank_nxt  = rom_bank_r;
    ram_bank_nxt  = ram_bank_r;
    ram_en_nxt    = ram_en_r;
    bank_mode_nxt = bank_mode_r;
    if (accept && req == cbm_pkg::REQ_ROM_WR) begin
      case (kind_r)
        cbm_pkg::KIND_MBC1: begin
          if (addr <= 16'h1FFF) begin
            ram_en_nxt = (val[3:0] == 4'hA);
          end else if (addr <= 16'h3FFF) begin
            rom_bank_nxt = (val[4:0] == 5'd0) ? 9'd1 : {4'd0, val[4:0]};
          end else if (addr <= 16'h5FFF) begin
            ram_bank_nxt = {2'd0, val[1:0]};
          end else if (addr <= 16'h7FFF) begin
            bank_mode_nxt = val[0];
          end
        end
        cbm_pkg::KIND_MBC2: begin
          if (addr <= 16'h3FFF) begin
            if (!addr[8]) begin
              ram_en_nxt = (val[3:0] == 4'hA);
            end else begin
              rom_bank_nxt = (val[3:0] == 4'd0) ? 9'd1 : {5'd0, val[3:0]};
            end
          end
        end
        cbm_pkg::KIND_MBC3: begin
          if (addr <= 16'h1FFF) begin
            ram_en_nxt = (val[3:0] == 4'hA);
          end else if (addr <= 16'h3FFF) begin
            rom_bank_nxt = (val[6:0] == 7'd0) ? 9'd1 : {2'd0, val[6:0]};
          end else if (addr <= 16'h5FFF) begin
            ram_bank_nxt = val[3:0];
          end
        end
        cbm_pkg::KIND_MBC5: begin
          if (addr <= 16'h1FFF) begin
            ram_en_nxt = (val[3:0] == 4'hA);
          end else if (addr <= 16'h2FFF) begin
            rom_bank_nxt = {rom_bank_r[8], val};
          end else if (addr <= 16'h3FFF) begin
            rom_bank_nxt = {val[0], rom_bank_r[7:0]};
          end else if (addr <= 16'h5FFF) begin
            ram_bank_nxt = val[3:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_bank_r  <= 9'd1;
      ram_bank_r  <= '0;
      ram_en_r    <= 1'b0;
      bank_mode_r <= 1'b0;
    end else begin
      rom_bank_r  <= rom_bank_nxt;
      ram_bank_r  <= ram_bank_nxt;
      ram_en_r    <= ram_en_nxt;
      bank_mode_r <= bank_mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req_r    <= req;
      s1_ram_ok_r <= ram_ok;
      s1_addr_r   <= ram_off[RAW-1:0];
      s1_wval_r   <= wval;
      s1_raddr_r  <= (rom_ok && req == cbm_pkg::REQ_ROM_RD) ? rom_off[RABW-1:0] : '0;
      s1_rvalid_r <= rom_ok && (req == cbm_pkg::REQ_ROM_RD);
    end
  end

  cbm_ram u_ram (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (accept),
    .rd_addr  (ram_off[RAW-1:0]),
    .rd_data  (old_byte),
    .wr       (wr),
    .clr_busy (clr_busy)
  );

  // read-modify-write stage
  always_comb begin
    s1_we   = s1_ram_ok_r && (s1_req_r == cbm_pkg::REQ_RAM_WR) && (old_byte != s1_wval_r);
    wr.en   = s1_adv && s1_we;
    wr.addr = s1_addr_r;
    wr.data = s1_wval_r;
    rd_byte = cbm_pkg::BYTE_ERASED;
    if (s1_ram_ok_r && s1_req_r == cbm_pkg::REQ_RAM_RD) begin
      rd_byte = (kind_r == cbm_pkg::KIND_MBC2) ? {4'hF, old_byte[3:0]} : old_byte;
    end
    dirty_nxt = dirty_r;
    count_nxt = count_r;
    if (s1_we && has_bat_r) begin
      dirty_nxt = 1'b1;
      count_nxt = count_r + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dirty_r <= 1'b0;
      count_r <= '0;
    end else if (s1_adv) begin
      dirty_r <= dirty_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= cbm_pkg::OUT_TDATA_W'({count_nxt, dirty_nxt, s1_raddr_r, rd_byte});
      out_user_r <= s1_rvalid_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
`default_nettype wire

// ===== design/cbm_ram.sv =====
`default_nettype none
module cbm_ram (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      rd_en,
  input  wire logic [cbm_pkg::RAM_AW-1:0] rd_addr,
  output logic      [7:0]                rd_data,
  input  wire cbm_pkg::ram_wr_t          wr,
  output logic                           clr_busy
);

  logic [7:0]                 mem [cbm_pkg::RAM_DEPTH];
  logic [7:0]                 q_r;
  logic                       byp_hit_r;
  logic [7:0]                 byp_data_r;
  logic                       clr_busy_r;
  logic [cbm_pkg::RAM_AW-1:0] clr_addr_r;

  // sweep after reset fills every byte with the erased value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == cbm_pkg::RAM_AW'(cbm_pkg::RAM_DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= cbm_pkg::BYTE_ERASED;
    end else if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // read before write, same-edge write forwarded
  always_ff @(posedge clk) begin
    if (rd_en) begin
      q_r        <= mem[rd_addr];
      byp_hit_r  <= wr.en && (wr.addr == rd_addr);
      byp_data_r <= wr.data;
    end
  end

  assign rd_data  = byp_hit_r ? byp_data_r : q_r;
  assign clr_busy = clr_busy_r;

endmodule
`default_nettype wire

// ===== design/cbm_checker.sv =====
`default_nettype none
module cbm_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic [cbm_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input wire logic                             out_tuser
);

  localparam int DIRTY_BIT = 8 + cbm_pkg::ROM_ADDR_BITS;

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result word valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result word changed");

  a_dirty_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tdata[DIRTY_BIT] |=> !out_tvalid || out_tdata[DIRTY_BIT])
    else $error("save dirty flag cleared");

  a_count_dirty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[DIRTY_BIT+32:DIRTY_BIT+1] != 32'd0) |-> out_tdata[DIRTY_BIT])
    else $error("changes counted without dirty flag");

  a_rom_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser ? (out_tdata[7:0] == 8'hFF)
                              : (out_tdata[DIRTY_BIT-1:8] == '0)))
    else $error("rom result fields inconsistent");

endmodule

bind cartridge_bank_mapper cbm_checker u_cbm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire
